### design/shape_outline_point_generator_defines.svh
// Assertion macros for the checks in the top module of this block.
`ifndef SHAPE_OUTLINE_POINT_GENERATOR_DEFINES_SVH
`define SHAPE_OUTLINE_POINT_GENERATOR_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SOPG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SOPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/sopg_pkg.sv
`default_nettype none
package sopg_pkg;

   localparam int MAX_POINTS    = 64;
   localparam int CORDIC_STAGES = 16;

   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int COORD_W    = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int CW       = 34;
   localparam int N_W      = 7;
   localparam int DEN_W    = 8;
   localparam int P_W      = 44;
   localparam int NUM_W    = 48;
   localparam int DIV_STEP = 8;
   localparam int DIV_STAGES = NUM_W / DIV_STEP;
   localparam int XW       = 50;
   localparam int ZW       = 34;
   localparam int X0_W     = 39;

   localparam logic [31:0] SQRT3_HALF_Q32  = 32'd3719550787;
   localparam logic [31:0] CORDIC_GAIN_INV = 32'h9B74EDA8;

   localparam logic [1:0] KIND_TRIANGLE  = 2'd0;
   localparam logic [1:0] KIND_RECTANGLE = 2'd1;
   localparam logic [1:0] KIND_CIRCLE    = 2'd2;
   localparam logic [1:0] KIND_RESERVED  = 2'd3;

   localparam logic [1:0] STYLE_ISOSCELES   = 2'd0;
   localparam logic [1:0] STYLE_EQUILATERAL = 2'd1;
   localparam logic [1:0] STYLE_SCALENE     = 2'd2;

   typedef enum logic [2:0] {
      REG_SHAPE_KIND,
      REG_TRIANGLE_STYLE,
      REG_SHAPE_WIDTH,
      REG_SHAPE_HEIGHT,
      REG_APEX_SHIFT,
      REG_CIRCLE_RADIUS
   } csr_reg_type;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         style;
      logic [30:0]        width;
      logic [30:0]        height;
      logic signed [31:0] apex;
      logic [30:0]        radius;
      logic [30:0]        eq_height;
      logic [X0_W-1:0]    cordic_x0;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic ok;
      logic circle;
      logic neg_x;
      logic neg_y;
      logic flip;
   } ctrl_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_lane_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [DEN_W-1:0] den;
      div_lane_type     x;
      div_lane_type     y;
   } div_type;

   typedef struct packed {
      ctrl_type              ctrl;
      logic signed [XW-1:0]  x;
      logic signed [XW-1:0]  y;
      logic signed [ZW-1:0]  z;
   } rot_type;

endpackage
`default_nettype wire

### design/sopg_req_if.sv
`default_nettype none
interface sopg_req_if;
   logic                      valid;
   logic                      ready;
   logic [sopg_pkg::IDX_W-1:0] vertex_sel;
   logic [sopg_pkg::CNT_W-1:0] vertex_total;

   modport source (output valid, output vertex_sel, output vertex_total, input ready);
   modport sink (input valid, input vertex_sel, input vertex_total, output ready);
endinterface
`default_nettype wire

### design/sopg_rsp_if.sv
`default_nettype none
interface sopg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sopg_pkg::COORD_W-1:0] x_pos;
   logic signed [sopg_pkg::COORD_W-1:0] y_pos;
   logic                               status;

   modport source (output valid, output x_pos, output y_pos, output status, input ready);
   modport sink (input valid, input x_pos, input y_pos, input status, output ready);
endinterface
`default_nettype wire

### design/shape_outline_point_generator.sv
`default_nettype none
// Channel  | Direction | Handshake    | Payload
// req_bus  | in        | valid/ready  | vertex_sel, vertex_total
// rsp_bus  | out       | valid/ready  | x_pos, y_pos, status
// csr_*    | in/out    | APB, ready 1 | six shape registers at 4*i
//
// One beat enters per cycle unless the output is held. It passes setup stages A to D,
// the divider stages, with eight quotient bits per stage, the CORDIC entry stage, the
// rotation stages, one CORDIC rotation each, the post stage and the output register.
// Reset is synchronous and clears the valid bits of every stage and the registers
// to their defaults. When the output beat is held by the sink, the whole pipeline
// freezes in place, so nothing is lost or repeated.
module shape_outline_point_generator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sopg_req_if.sink                             req_bus,
   sopg_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sopg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sopg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [sopg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import sopg_pkg::*;
`include "shape_outline_point_generator_defines.svh"

   localparam logic signed [XW-1:0] COORD_MAX = XW'(2147483647);
   localparam logic signed [XW-1:0] COORD_MIN = ~COORD_MAX;

   cfg_type cfg;
   div_type setup_d, div_d;
   rot_type rot_r;
   logic    adv;

   // The pipeline moves whenever the output register is empty or being taken.
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   sopg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sopg_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_bus.valid),
      .idx      (req_bus.vertex_sel),
      .count    (req_bus.vertex_total),
      .cfg      (cfg),
      .out_d    (setup_d)
   );

   sopg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in_d  (setup_d),
      .out_d (div_d)
   );

   sopg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .x0    (cfg.cordic_x0),
      .in_d  (div_d),
      .out_r (rot_r)
   );

   // Post stage: undo the fold and add the rounding half for circle points.
   ctrl_type             p_ctrl_ff;
   logic signed [XW-1:0] p_x_ff, p_y_ff, p_x_in, p_y_in;

   always_comb begin
      if (rot_r.ctrl.circle) begin
         p_x_in = rot_r.ctrl.flip ? XW'(128) - rot_r.x : rot_r.x + XW'(128);
         p_y_in = rot_r.ctrl.flip ? XW'(128) - rot_r.y : rot_r.y + XW'(128);
      end else begin
         p_x_in = rot_r.x;
         p_y_in = rot_r.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         p_ctrl_ff <= rot_r.ctrl;
      end
      if (adv) begin
         p_x_ff <= p_x_in;
         p_y_ff <= p_y_in;
      end
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [XW-1:0] v);
      if (v > COORD_MAX) begin
         clamp_coord = COORD_W'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         clamp_coord = COORD_W'(COORD_MIN);
      end else begin
         clamp_coord = COORD_W'(v);
      end
   endfunction

   // Output register: drop the extra fraction bits of circle points, saturate, and
   // zero an invalid beat.
   logic                      out_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                      out_status_ff;
   logic signed [XW-1:0]      fx, fy;

   always_comb begin
      fx = p_ctrl_ff.circle ? p_x_ff >>> 8 : p_x_ff;
      fy = p_ctrl_ff.circle ? p_y_ff >>> 8 : p_y_ff;
      out_x_in = p_ctrl_ff.ok ? clamp_coord(fx) : '0;
      out_y_in = p_ctrl_ff.ok ? clamp_coord(fy) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= p_ctrl_ff.valid;
      end
      if (adv) begin
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_status_ff <= !p_ctrl_ff.ok;
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.x_pos  = out_x_ff;
   assign rsp_bus.y_pos  = out_y_ff;
   assign rsp_bus.status = out_status_ff;

   // An invalid point always carries zero coordinates.
   `SOPG_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_bus.valid && rsp_bus.status, rsp_bus.x_pos == 0 && rsp_bus.y_pos == 0, "invalid beat with non-zero coordinates")
   // A held result must freeze the input side as well.
   `SOPG_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "input taken while the output is held")
   // Reset empties the output register.
   `SOPG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_bus.valid, "result offered straight after reset")
endmodule
`default_nettype wire

### design/sopg_csr.sv
`default_nettype none
module sopg_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [sopg_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [sopg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [sopg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output sopg_pkg::cfg_type                    cfg
);
   import sopg_pkg::*;

   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         style_ff, style_in;
   logic [30:0]        width_ff, width_in;
   logic [30:0]        height_ff, height_in;
   logic signed [31:0] apex_ff, apex_in;
   logic [30:0]        radius_ff, radius_in;
   logic [30:0]        eq_height_ff, eq_height_in;
   logic [X0_W-1:0]    x0_ff, x0_in;
   logic [62:0]        eq_prod;
   logic [62:0]        x0_prod;
   logic               wr;
   csr_reg_type        reg_sel;

   assign wr      = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_comb begin
      kind_in   = kind_ff;
      style_in  = style_ff;
      width_in  = width_ff;
      height_in = height_ff;
      apex_in   = apex_ff;
      radius_in = radius_ff;
      if (wr) begin
         unique case (reg_sel)
            REG_SHAPE_KIND:     kind_in   = pwdata[1:0];
            REG_TRIANGLE_STYLE: style_in  = pwdata[1:0];
            REG_SHAPE_WIDTH:    width_in  = pwdata[30:0];
            REG_SHAPE_HEIGHT:   height_in = pwdata[30:0];
            REG_APEX_SHIFT:     apex_in   = $signed(pwdata);
            REG_CIRCLE_RADIUS:  radius_in = pwdata[30:0];
            default: ;
         endcase
      end
   end

   // Derived values are registered and follow the registers in the cycle after.
   always_comb begin
      eq_prod      = 63'(width_ff) * 63'(SQRT3_HALF_Q32) + 63'(64'h8000_0000);
      eq_height_in = eq_prod[62:32];
      x0_prod      = 63'(radius_ff) * 63'(CORDIC_GAIN_INV);
      x0_in        = x0_prod[62:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_RECTANGLE;
         style_ff  <= STYLE_ISOSCELES;
         width_ff  <= 31'd65536;
         height_ff <= 31'd65536;
         apex_ff   <= 32'sd0;
         radius_ff <= 31'd65536;
      end else begin
         kind_ff   <= kind_in;
         style_ff  <= style_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         apex_ff   <= apex_in;
         radius_ff <= radius_in;
      end
      eq_height_ff <= eq_height_in;
      x0_ff        <= x0_in;
   end

   always_comb begin
      unique case (reg_sel)
         REG_SHAPE_KIND:     prdata = 32'(kind_ff);
         REG_TRIANGLE_STYLE: prdata = 32'(style_ff);
         REG_SHAPE_WIDTH:    prdata = 32'(width_ff);
         REG_SHAPE_HEIGHT:   prdata = 32'(height_ff);
         REG_APEX_SHIFT:     prdata = apex_ff;
         REG_CIRCLE_RADIUS:  prdata = 32'(radius_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.kind      = kind_ff;
   assign cfg.style     = style_ff;
   assign cfg.width     = width_ff;
   assign cfg.height    = height_ff;
   assign cfg.apex      = apex_ff;
   assign cfg.radius    = radius_ff;
   assign cfg.eq_height = eq_height_ff;
   assign cfg.cordic_x0 = x0_ff;
endmodule
`default_nettype wire

### design/sopg_setup.sv
`default_nettype none
module sopg_setup (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [sopg_pkg::IDX_W-1:0]  idx,
   input  wire logic [sopg_pkg::CNT_W-1:0]  count,
   input  wire sopg_pkg::cfg_type           cfg,
   output sopg_pkg::div_type                out_d
);
   import sopg_pkg::*;

   // Stage A: checks on the beat itself and the spread of surplus points.
   logic             a_valid_ff, a_ok_ff, a_ok_in;
   logic [IDX_W-1:0] a_idx_ff;
   logic [CNT_W-1:0] a_count_ff;
   logic [5:0]       a_base_ff, a_base_in;
   logic [1:0]       a_rem_ff, a_rem_in;
   logic             corners4;
   logic [CNT_W-1:0] surplus;
   logic [15:0]      base3_prod;
   logic [CNT_W-1:0] rem3;

   always_comb begin
      corners4   = (cfg.kind == KIND_RECTANGLE);
      surplus    = count - (corners4 ? 7'd4 : 7'd3);
      // Division by three through the reciprocal 171/512, exact below 128.
      base3_prod = 16'(surplus) * 16'd171;
      a_base_in  = corners4 ? 6'(surplus >> 2) : base3_prod[14:9];
      rem3       = surplus - 7'({1'b0, a_base_in} << 1) - 7'(a_base_in);
      a_rem_in   = corners4 ? surplus[1:0] : rem3[1:0];
      a_ok_in    = (count >= 7'd3) && (int'(count) <= MAX_POINTS) &&
                   ({1'b0, idx} < count) && (cfg.kind != KIND_RESERVED) &&
                   (!corners4 || count >= 7'd4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
      if (adv) begin
         a_ok_ff    <= a_ok_in;
         a_idx_ff   <= idx;
         a_count_ff <= count;
         a_base_ff  <= a_base_in;
         a_rem_ff   <= a_rem_in;
      end
   end

   // Stage B: edge search and corner selection.
   function automatic logic signed [CW-1:0] corner_x(input logic rect, input logic [1:0] st,
                                                      input logic [1:0] e,
                                                      input logic [30:0] w,
                                                      input logic signed [31:0] apex);
      logic signed [CW-1:0] wv;
      wv = $signed(CW'(w));
      if (rect) begin
         corner_x = (e == 2'd1 || e == 2'd2) ? wv : -wv;
      end else begin
         priority case (e)
            2'd0:    corner_x = (st == STYLE_SCALENE) ? CW'(apex) <<< 1 : '0;
            2'd1:    corner_x = wv;
            default: corner_x = -wv;
         endcase
      end
   endfunction

   function automatic logic signed [CW-1:0] corner_y(input logic rect, input logic [1:0] e,
                                                      input logic [30:0] h);
      logic signed [CW-1:0] hv;
      hv = $signed(CW'(h));
      if (rect) begin
         corner_y = (e == 2'd0 || e == 2'd1) ? -hv : hv;
      end else begin
         corner_y = (e == 2'd0) ? -hv : hv;
      end
   endfunction

   ctrl_type             b_ctrl_ff, b_ctrl_in;
   logic signed [CW-1:0] b_ax_ff, b_ay_ff, b_bx_ff, b_by_ff;
   logic signed [CW-1:0] b_ax_in, b_ay_in, b_bx_in, b_by_in;
   logic [N_W-1:0]       b_n_ff, b_n_in, b_s_ff, b_s_in;
   logic [IDX_W-1:0]     b_idx_ff;
   logic [CNT_W-1:0]     b_count_ff;
   logic [N_W-1:0]       seg0, seg1, seg2, seg3, start1, start2, start3, idx7, start_sel;
   logic [1:0]           edge_sel, edge_next;
   logic                 rect_b;
   logic [30:0]          h_sel;
   logic                 size_ok;

   always_comb begin
      rect_b = (cfg.kind == KIND_RECTANGLE);
      seg0   = N_W'(a_base_ff) + 7'd1 + N_W'(a_rem_ff > 2'd0);
      seg1   = N_W'(a_base_ff) + 7'd1 + N_W'(a_rem_ff > 2'd1);
      seg2   = N_W'(a_base_ff) + 7'd1 + N_W'(a_rem_ff > 2'd2);
      seg3   = N_W'(a_base_ff) + 7'd1;
      start1 = seg0;
      start2 = start1 + seg1;
      start3 = start2 + seg2;
      idx7   = N_W'(a_idx_ff);
      if (idx7 < start1) begin
         edge_sel = 2'd0; start_sel = '0; b_n_in = seg0;
      end else if (idx7 < start2) begin
         edge_sel = 2'd1; start_sel = start1; b_n_in = seg1;
      end else if (!rect_b || idx7 < start3) begin
         edge_sel = 2'd2; start_sel = start2; b_n_in = seg2;
      end else begin
         edge_sel = 2'd3; start_sel = start3; b_n_in = seg3;
      end
      b_s_in    = idx7 - start_sel;
      edge_next = (!rect_b && edge_sel == 2'd2) ? 2'd0 : edge_sel + 2'd1;
      h_sel     = (!rect_b && cfg.style == STYLE_EQUILATERAL) ? cfg.eq_height : cfg.height;
      unique case (cfg.kind)
         KIND_TRIANGLE:  size_ok = (cfg.width != '0) && (h_sel != '0);
         KIND_RECTANGLE: size_ok = (cfg.width != '0) && (cfg.height != '0);
         KIND_CIRCLE:    size_ok = (cfg.radius != '0);
         default:        size_ok = 1'b0;
      endcase
      b_ax_in = corner_x(rect_b, cfg.style, edge_sel, cfg.width, cfg.apex);
      b_bx_in = corner_x(rect_b, cfg.style, edge_next, cfg.width, cfg.apex);
      b_ay_in = corner_y(rect_b, edge_sel, h_sel);
      b_by_in = corner_y(rect_b, edge_next, h_sel);
      b_ctrl_in        = '0;
      b_ctrl_in.valid  = a_valid_ff;
      b_ctrl_in.ok     = a_ok_ff && size_ok;
      b_ctrl_in.circle = (cfg.kind == KIND_CIRCLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         b_ctrl_ff <= b_ctrl_in;
      end
      if (adv) begin
         b_ax_ff    <= b_ax_in;
         b_ay_ff    <= b_ay_in;
         b_bx_ff    <= b_bx_in;
         b_by_ff    <= b_by_in;
         b_n_ff     <= b_n_in;
         b_s_ff     <= b_s_in;
         b_idx_ff   <= a_idx_ff;
         b_count_ff <= a_count_ff;
      end
   end

   // Stage C: the products of the interpolation and the circle phase numerator.
   ctrl_type                  c_ctrl_ff;
   logic signed [P_W-1:0]     c_p0x_ff, c_p1x_ff, c_p0y_ff, c_p1y_ff;
   logic signed [P_W-1:0]     c_p0x_in, c_p1x_in, c_p0y_in, c_p1y_in;
   logic signed [CW:0]        dx, dy;
   logic signed [N_W:0]       n_s, s_s;
   logic [N_W-1:0]            c_n_ff;
   logic [NUM_W-1:0]          c_cnum_ff, c_cnum_in;
   logic [CNT_W-1:0]          c_count_ff;

   always_comb begin
      n_s      = $signed({1'b0, b_n_ff});
      s_s      = $signed({1'b0, b_s_ff});
      dx       = (CW + 1)'(b_bx_ff) - (CW + 1)'(b_ax_ff);
      dy       = (CW + 1)'(b_by_ff) - (CW + 1)'(b_ay_ff);
      c_p0x_in = P_W'(b_ax_ff) * P_W'(n_s);
      c_p0y_in = P_W'(b_ay_ff) * P_W'(n_s);
      c_p1x_in = P_W'(dx) * P_W'(s_s);
      c_p1y_in = P_W'(dy) * P_W'(s_s);
      c_cnum_in = NUM_W'({b_idx_ff, 32'b0}) + NUM_W'(b_count_ff[CNT_W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         c_ctrl_ff <= b_ctrl_ff;
      end
      if (adv) begin
         c_p0x_ff   <= c_p0x_in;
         c_p1x_ff   <= c_p1x_in;
         c_p0y_ff   <= c_p0y_in;
         c_p1y_ff   <= c_p1y_in;
         c_n_ff     <= b_n_ff;
         c_cnum_ff  <= c_cnum_in;
         c_count_ff <= b_count_ff;
      end
   end

   // Stage D: rounded numerators folded to magnitudes for a floor division.
   div_type               d_ff, d_in;
   logic signed [P_W-1:0] numx, numy;
   logic [DEN_W-1:0]      den2n;

   always_comb begin
      den2n = DEN_W'({c_n_ff, 1'b0});
      numx  = c_p0x_ff + c_p1x_ff + $signed(P_W'(c_n_ff));
      numy  = c_p0y_ff + c_p1y_ff + $signed(P_W'(c_n_ff));
      d_in  = '0;
      d_in.ctrl = c_ctrl_ff;
      if (c_ctrl_ff.circle) begin
         d_in.den   = DEN_W'(c_count_ff);
         d_in.x.num = c_cnum_ff;
      end else begin
         d_in.den        = den2n;
         d_in.ctrl.neg_x = numx[P_W-1];
         d_in.ctrl.neg_y = numy[P_W-1];
         d_in.x.num = numx[P_W-1] ? NUM_W'(~numx) + NUM_W'(den2n) : NUM_W'(numx);
         d_in.y.num = numy[P_W-1] ? NUM_W'(~numy) + NUM_W'(den2n) : NUM_W'(numy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.ctrl.valid <= 1'b0;
      end else if (adv) begin
         d_ff <= d_in;
      end
   end

   assign out_d = d_ff;
endmodule
`default_nettype wire

### design/sopg_divider.sv
`default_nettype none
module sopg_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire sopg_pkg::div_type in_d,
   output sopg_pkg::div_type      out_d
);
   import sopg_pkg::*;

   // Restoring division, DIV_STEP (eight) quotient bits per stage; the quotient
   // replaces the numerator from the bottom.
   function automatic div_lane_type div_steps(input div_lane_type lane,
                                              input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      div_lane_type   l;
      l = lane;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {l.rem, l.num[NUM_W-1]};
         l.num = {l.num[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial    = trial - {1'b0, den};
            l.num[0] = 1'b1;
         end
         l.rem = trial[DEN_W-1:0];
      end
      div_steps = l;
   endfunction

   div_type stage_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      div_type src, stage_in;
      if (g == 0) begin : g_first
         assign src = in_d;
      end else begin : g_next
         assign src = stage_ff[g-1];
      end
      always_comb begin
         stage_in   = src;
         stage_in.x = div_steps(src.x, src.den);
         stage_in.y = div_steps(src.y, src.den);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[g].ctrl.valid <= 1'b0;
         end else if (adv) begin
            stage_ff[g] <= stage_in;
         end
      end
   end

   assign out_d = stage_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

### design/sopg_cordic.sv
`default_nettype none
module sopg_cordic (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic [sopg_pkg::X0_W-1:0]  x0,
   input  wire sopg_pkg::div_type          in_d,
   output sopg_pkg::rot_type               out_r
);
   import sopg_pkg::*;

   // Entry stage: fold the phase into the right half plane, or turn the
   // polygon quotients back into signed coordinates.
   rot_type            e_ff, e_in;
   logic signed [31:0] a0;
   logic signed [32:0] a33;
   logic signed [XW-1:0] qx, qy;

   always_comb begin
      a0   = $signed(in_d.x.num[31:0] - 32'h4000_0000);
      a33  = 33'(a0);
      e_in = '0;
      e_in.ctrl = in_d.ctrl;
      qx = $signed(XW'(in_d.x.num));
      qy = $signed(XW'(in_d.y.num));
      if (in_d.ctrl.circle) begin
         if (a33 > 33'sh0_4000_0000) begin
            a33 = a33 - 33'sh0_8000_0000;
            e_in.ctrl.flip = 1'b1;
         end else if (a33 < -33'sh0_4000_0000) begin
            a33 = a33 + 33'sh0_8000_0000;
            e_in.ctrl.flip = 1'b1;
         end
         e_in.x = $signed(XW'(x0));
         e_in.y = '0;
         e_in.z = ZW'(a33);
      end else begin
         e_in.x = in_d.ctrl.neg_x ? -qx : qx;
         e_in.y = in_d.ctrl.neg_y ? -qy : qy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.ctrl.valid <= 1'b0;
      end else if (adv) begin
         e_ff <= e_in;
      end
   end

   rot_type rot_ff [CORDIC_STAGES];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      rot_type              src, rot_in;
      logic signed [ZW-1:0] ang;
      if (k == 0) begin : g_first
         assign src = e_ff;
      end else begin : g_next
         assign src = rot_ff[k-1];
      end
      assign ang = $signed(ZW'(ATAN_TURNS[k]));
      always_comb begin
         rot_in = src;
         if (src.ctrl.circle) begin
            if (src.z >= 0) begin
               rot_in.x = src.x - (src.y >>> k);
               rot_in.y = src.y + (src.x >>> k);
               rot_in.z = src.z - ang;
            end else begin
               rot_in.x = src.x + (src.y >>> k);
               rot_in.y = src.y - (src.x >>> k);
               rot_in.z = src.z + ang;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rot_ff[k].ctrl.valid <= 1'b0;
         end else if (adv) begin
            rot_ff[k] <= rot_in;
         end
      end
   end

   assign out_r = rot_ff[CORDIC_STAGES-1];
endmodule
`default_nettype wire

### test/sopg_tb_if.sv
`default_nettype none
// The block's channel interfaces live with the design; this file only holds
// a small record type shared by the checker and the top.
package sopg_tb_pkg;
   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         style;
      logic [30:0]        width;
      logic [30:0]        height;
      logic signed [31:0] apex;
      logic [30:0]        radius;
   } shape_setting_type;
endpackage
`default_nettype wire

### test/sopg_checker.sv
`default_nettype none
module sopg_checker
   import sopg_pkg::*;
   import sopg_tb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [IDX_W-1:0]  req_index,
   input  wire logic [CNT_W-1:0]  req_count,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [31:0]       rsp_x,
   input  wire logic [31:0]       rsp_y,
   input  wire logic              rsp_status,
   input  wire shape_setting_type shape,
   output int                     fail_count,
   output int                     pending,
   output int                     points_seen,
   output int                     bad_seen
);
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        status;
   } vertex_type;

   vertex_type vertex_queue[$];

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void edge_point(longint cx[4], longint cy[4], longint corners,
                                      longint idx, longint count,
                                      output longint px, output longint py);
      longint surplus, at, seg, s, n, e, nx;
      surplus = count - corners;
      at = 0; s = 0; n = 1; e = 0;
      for (longint k = 0; k < corners; k++) begin
         seg = 1 + surplus / corners + ((k < surplus % corners) ? 1 : 0);
         if (idx < at + seg) begin
            e = k; s = idx - at; n = seg;
            break;
         end
         at += seg;
      end
      nx = (e + 1) % corners;
      px = sat32(floor_div(cx[e] * n + (cx[nx] - cx[e]) * s + n, 2 * n));
      py = sat32(floor_div(cy[e] * n + (cy[nx] - cy[e]) * s + n, 2 * n));
   endfunction

   function automatic void round_point(longint idx, longint count,
                                       output longint px, output longint py);
      logic [63:0] phase;
      longint a, x, y, z, dx, dy;
      bit flip;
      phase = ((64'(idx) << 32) + 64'(count / 2)) / 64'(count);
      a = longint'((phase - 64'h40000000) & 64'hFFFFFFFF);
      flip = 0;
      if (a >= 64'sh80000000) a -= 64'sh100000000;
      if (a > 64'sh40000000) begin
         a -= 64'sh80000000; flip = 1;
      end else if (a < -64'sh40000000) begin
         a += 64'sh80000000; flip = 1;
      end
      x = longint'((64'(shape.radius) * 64'(CORDIC_GAIN_INV)) >> 24);
      y = 0;
      z = a;
      for (int k = 0; k < CORDIC_STAGES && k < 24; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      px = sat32(floor_shift(x + 128, 8));
      py = sat32(floor_shift(y + 128, 8));
   endfunction

   function automatic vertex_type predict_vertex(longint idx, longint count);
      vertex_type v;
      longint cx[4], cy[4], h, w, px, py;
      bit ok;
      px = 0; py = 0;
      ok = count >= 3 && count <= MAX_POINTS && idx < count;
      w = longint'(shape.width);
      if (ok) begin
         if (shape.kind == KIND_TRIANGLE) begin
            h = longint'(shape.height);
            if (shape.style == STYLE_EQUILATERAL)
               h = longint'((64'(shape.width) * 64'(SQRT3_HALF_Q32) + 64'h80000000) >> 32);
            if (w == 0 || h == 0) ok = 0;
            else begin
               cx[0] = (shape.style == STYLE_SCALENE) ? 2 * longint'(shape.apex) : 0;
               cy[0] = -h;
               cx[1] = w;  cy[1] = h;
               cx[2] = -w; cy[2] = h;
               cx[3] = 0;  cy[3] = 0;
               edge_point(cx, cy, 3, idx, count, px, py);
            end
         end else if (shape.kind == KIND_RECTANGLE) begin
            h = longint'(shape.height);
            if (w == 0 || h == 0 || count < 4) ok = 0;
            else begin
               cx[0] = -w; cy[0] = -h;
               cx[1] = w;  cy[1] = -h;
               cx[2] = w;  cy[2] = h;
               cx[3] = -w; cy[3] = h;
               edge_point(cx, cy, 4, idx, count, px, py);
            end
         end else if (shape.kind == KIND_CIRCLE) begin
            if (shape.radius == 0) ok = 0;
            else round_point(idx, count, px, py);
         end else ok = 0;
      end
      if (!ok) begin
         px = 0; py = 0;
      end
      v.x = px[31:0];
      v.y = py[31:0];
      v.status = !ok;
      return v;
   endfunction

   always @(posedge clock) begin
      vertex_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         points_seen <= 0;
         bad_seen <= 0;
         pending <= 0;
      end else begin
         if (req_valid && req_ready)
            vertex_queue.push_back(predict_vertex(longint'(req_index), longint'(req_count)));
         if (rsp_valid && rsp_ready) begin
            points_seen <= points_seen + 1;
            if (rsp_status) bad_seen <= bad_seen + 1;
            if (vertex_queue.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               want = vertex_queue.pop_front();
               if (want.x !== rsp_x) begin
                  $error("x_pos expected %0d got %0d", $signed(want.x), $signed(rsp_x));
                  errs++;
               end
               if (want.y !== rsp_y) begin
                  $error("y_pos expected %0d got %0d", $signed(want.y), $signed(rsp_y));
                  errs++;
               end
               if (want.status !== rsp_status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= vertex_queue.size();
      end
   end
endmodule
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
   import sopg_pkg::*;
   import sopg_tb_pkg::*;

   // Longest quiet spell before the run is declared hung. Random stalls are short,
   // so this is generous.
   localparam int QUIET_LIMIT = 5000;
   localparam int PIPE_DEPTH  = 40;

   logic clock = 0;
   logic reset = 1;
   always #4 clock = ~clock;

   sopg_req_if req_bus ();
   sopg_rsp_if rsp_bus ();

   logic                  csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // The testbench's own copy of the shape registers, read by the checker.
   shape_setting_type shape;
   int fail_count, pending, points_seen, bad_seen;
   int quiet_cycles = 0;
   int settings_used = 0;
   bit sender_calm = 0, receiver_calm = 0;

   shape_outline_point_generator u_dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   sopg_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .req_index(req_bus.vertex_sel), .req_count(req_bus.vertex_total),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
      .rsp_x(rsp_bus.x_pos), .rsp_y(rsp_bus.y_pos), .rsp_status(rsp_bus.status),
      .shape(shape), .fail_count(fail_count), .pending(pending),
      .points_seen(points_seen), .bad_seen(bad_seen)
   );

   initial begin
      req_bus.valid = 0;
      req_bus.vertex_sel = '0;
      req_bus.vertex_total = '0;
      rsp_bus.ready = 0;
   end

   // The receiver drops ready about a third of the time, except while it is
   // told to stay calm, which gives a long stretch of full-rate draining.
   always @(negedge clock)
      rsp_bus.ready <= receiver_calm || ($urandom_range(99) >= 33);

   // The watchdog counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One APB write: setup then access. The shadow copy changes at the
   // same edge as the block's register.
   task automatic csr_write(csr_reg_type which, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(which));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      case (which)
         REG_SHAPE_KIND:     shape.kind   = value[1:0];
         REG_TRIANGLE_STYLE: shape.style  = value[1:0];
         REG_SHAPE_WIDTH:    shape.width  = value[30:0];
         REG_SHAPE_HEIGHT:   shape.height = value[30:0];
         REG_APEX_SHIFT:     shape.apex   = value;
         REG_CIRCLE_RADIUS:  shape.radius = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // Offers one beat, idling first at random unless told to stay calm, and
   // keeps valid high until the block takes it.
   task automatic send_point(int idx, int count);
      while (!sender_calm && $urandom_range(99) < 33) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.vertex_sel <= idx[IDX_W-1:0];
      req_bus.vertex_total <= count[CNT_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Lets the pipeline drain so the registers may be rewritten safely.
   task automatic wait_idle();
      req_bus.valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_DEPTH) @(negedge clock);
   endtask

   task automatic apply_shape(logic [1:0] kind, logic [1:0] style, logic [31:0] w,
                              logic [31:0] h, logic [31:0] apex, logic [31:0] r);
      wait_idle();
      csr_write(REG_SHAPE_KIND, {30'd0, kind});
      csr_write(REG_TRIANGLE_STYLE, {30'd0, style});
      csr_write(REG_SHAPE_WIDTH, w);
      csr_write(REG_SHAPE_HEIGHT, h);
      csr_write(REG_APEX_SHIFT, apex);
      csr_write(REG_CIRCLE_RADIUS, r);
      settings_used++;
   endtask

   // Sizes are mostly modest, with the occasional extreme or zero.
   function automatic logic [31:0] pick_size();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'd0;
         2: return $urandom;
         default: return $urandom_range(32'h00400000, 1);
      endcase
   endfunction

   initial begin
      int count;
      shape = '{kind: KIND_RECTANGLE, style: STYLE_ISOSCELES, width: 31'd65536,
                height: 31'd65536, apex: 32'sd0, radius: 31'd65536};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: the reset shape with edge and invalid counts and indexes,
      // then extreme or zero sizes for triangles and circles, and the reserved kind.
      send_point(0, 4);
      send_point(63, 64);
      send_point(0, 2);
      send_point(2, 3);
      send_point(3, 3);
      send_point(5, 65);
      send_point(63, 127);
      send_point(0, 0);
      apply_shape(KIND_TRIANGLE, STYLE_ISOSCELES, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1);
      send_point(0, 3); send_point(1, 3); send_point(4, 7);
      apply_shape(KIND_TRIANGLE, STYLE_EQUILATERAL, 32'h7FFFFFFF, 0, 0, 1);
      send_point(2, 3); send_point(40, 64);
      apply_shape(KIND_TRIANGLE, STYLE_SCALENE, 32'd1, 32'd1, 32'h80000000, 0);
      send_point(0, 5); send_point(3, 5);
      apply_shape(KIND_TRIANGLE, 2'd3, 32'd0, 32'd5, 32'h7FFFFFFF, 0);
      send_point(1, 3);
      apply_shape(KIND_CIRCLE, STYLE_ISOSCELES, 1, 1, 0, 32'h7FFFFFFF);
      send_point(0, 3); send_point(16, 64); send_point(48, 64);
      apply_shape(KIND_CIRCLE, STYLE_ISOSCELES, 1, 1, 0, 0);
      send_point(1, 8);
      apply_shape(KIND_RESERVED, STYLE_ISOSCELES, 1, 1, 0, 1);
      send_point(1, 8);

      // Random part: twenty shapes of about 25 beats each, mostly walking the
      // outline in order, with stray indexes and counts mixed in.
      for (int round = 0; round < 20; round++) begin
         apply_shape(2'($urandom_range(3)), 2'($urandom_range(3)), pick_size(),
                     pick_size(), $urandom, pick_size());
         if (round == 10) receiver_calm = 1;
         if (round == 12) receiver_calm = 0;
         sender_calm = (round == 10 || round == 11);
         count = $urandom_range(64, 3);
         for (int k = 0; k < 25; k++) begin
            if ($urandom_range(9) < 8)
               send_point(k % count, count);
            else
               send_point($urandom_range(63), $urandom_range(127));
         end
      end
      sender_calm = 0;

      // Final drain, then a margin for anything the block might still emit.
      wait_idle();
      $display("Checked %0d points, %0d of them rejected, over %0d shape settings.",
               points_seen, bad_seen, settings_used);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
